// ===== rtl/rte_pkg.sv =====
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types, constants and a helper function of the RTT timeout estimator.
// ----------------------------------------------------------------------------
package rte_pkg;

	localparam int NUM_PEERS = 16;
	localparam int PEER_W    = 4;
	localparam int IDX_W     = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
	localparam int TICK_W    = 10;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_RETX   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_MIN    = 2'd1;
	localparam logic [1:0] CFG_MAX    = 2'd2;
	localparam logic [1:0] CFG_MARGIN = 2'd3;

	typedef struct packed {
		logic              enable;
		logic [TICK_W-1:0] min_ticks;
		logic [TICK_W-1:0] max_ticks;
		logic [TICK_W-1:0] margin_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [PEER_W-1:0] peer;
		logic [TICK_W-1:0] delay_ticks;
		logic [7:0]        send_count;
		logic [TICK_W-1:0] waited_ticks;
		logic [31:0]       now_ticks;
	} item_t;

	typedef struct packed {
		logic              initialized;
		logic              provisional;
		logic [13:0]       scaled_srtt;
		logic [12:0]       scaled_rttvar;
		logic [TICK_W-1:0] timeout_value;
		logic [12:0]       scaled_delivery;
		logic              delivery_seen;
		logic              backed_off;
		logic [31:0]       last_backoff_time;
	} entry_t;

	// Packed with the last declared field, peer_out, in the lowest bits.
	typedef struct packed {
		logic              is_provisional;
		logic [TICK_W-1:0] delivery_ticks;
		logic              delivery_valid;
		logic [TICK_W-1:0] rtt_variance;
		logic [TICK_W-1:0] smoothed_rtt;
		logic [TICK_W-1:0] timeout_ticks;
		logic              estimate_valid;
		logic              accepted;
		logic [PEER_W-1:0] peer_out;
	} result_t;

	function automatic logic [TICK_W-1:0] clamp_ticks(input logic [13:0] v,
			input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] hi);
		logic [TICK_W-1:0] r;
		if (v < 14'(lo)) begin
			r = lo;
		end else if (v > 14'(hi)) begin
			r = hi;
		end else begin
			r = v[TICK_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/rte_peer_table.sv =====
// ----------------------------------------------------------------------------
// rte_peer_table
// Per-peer estimator state in flip-flops, one read and one write port.
// ----------------------------------------------------------------------------
module rte_peer_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [rte_pkg::IDX_W-1:0] raddr,
	output rte_pkg::entry_t     rdata,
	input  logic                we,
	input  logic [rte_pkg::IDX_W-1:0] waddr,
	input  rte_pkg::entry_t     wdata
);
	import rte_pkg::*;

	entry_t entry_q [NUM_PEERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PEERS; i++) begin
				entry_q[i] <= '0;
			end
		end else if (we) begin
			entry_q[waddr] <= wdata;
		end
	end

	assign rdata = entry_q[raddr];

endmodule

// ===== rtl/rte_update.sv =====
// ----------------------------------------------------------------------------
// rte_update
// Next-state and report logic for one item applied to one peer entry.
// ----------------------------------------------------------------------------
module rte_update (
	input  rte_pkg::item_t  item,
	input  rte_pkg::cfg_t   cfg,
	input  rte_pkg::entry_t cur,
	output rte_pkg::entry_t nxt,
	output logic            we,
	output rte_pkg::result_t res
);
	import rte_pkg::*;

	logic              peer_ok;
	logic              sample_ok;
	logic              clean;
	logic              add;
	logic              seed;
	logic [12:0]       del_new;
	logic [9:0]        half;
	logic [13:0]       srtt_seed;
	logic [12:0]       rv_seed;
	logic [10:0]       s_cur;
	logic [10:0]       mag;
	logic [13:0]       srtt_bl;
	logic [12:0]       rv_bl0;
	logic [12:0]       rv_bl;
	logic [13:0]       srtt_new;
	logic [12:0]       rv_new;
	logic [12:0]       allow;
	logic [TICK_W-1:0] rto_new;
	logic [31:0]       diff;
	logic              too_soon;
	logic              retx_ok;
	logic [11:0]       grown;

	assign peer_ok = {1'b0, item.peer} < (PEER_W + 1)'(NUM_PEERS);

	// Delivery average
	assign del_new = cur.delivery_seen
		? 13'(cur.scaled_delivery - (cur.scaled_delivery >> 2) + 13'(item.delay_ticks))
		: 13'({item.delay_ticks, 2'b00});

	// RTT sample, with Karn's rule on retransmitted acks
	assign sample_ok = (item.send_count != 8'd0) && (item.delay_ticks <= cfg.max_ticks);
	assign clean     = (item.send_count == 8'd1);
	assign add       = clean || !cur.initialized;
	assign seed      = clean ? !(cur.initialized && !cur.provisional) : 1'b1;

	assign half      = (item.delay_ticks > 10'd1)
		? 10'((11'(item.delay_ticks) + 11'd1) >> 1) : 10'd1;
	assign srtt_seed = 14'({item.delay_ticks, 3'b000});
	assign rv_seed   = 13'({half, 2'b00});

	assign s_cur   = cur.scaled_srtt[13:3];
	assign mag     = (11'(item.delay_ticks) >= s_cur)
		? 11'(11'(item.delay_ticks) - s_cur) : 11'(s_cur - 11'(item.delay_ticks));
	assign srtt_bl = 14'(cur.scaled_srtt - 14'(s_cur) + 14'(item.delay_ticks));
	assign rv_bl0  = 13'(cur.scaled_rttvar - (cur.scaled_rttvar >> 2) + 13'(mag));
	assign rv_bl   = (rv_bl0 < 13'd4) ? 13'd4 : rv_bl0;

	assign srtt_new = seed ? srtt_seed : srtt_bl;
	assign rv_new   = seed ? rv_seed : rv_bl;
	assign allow    = (rv_new < 13'(cfg.margin_ticks)) ? 13'(cfg.margin_ticks) : rv_new;
	assign rto_new  = clamp_ticks(14'(14'(srtt_new[13:3]) + 14'(allow)),
		cfg.min_ticks, cfg.max_ticks);

	// Backoff on retransmit, at most once per timeout interval
	assign diff     = item.now_ticks - cur.last_backoff_time;
	assign too_soon = cur.backed_off && (diff[31] || diff < 32'(cur.timeout_value));
	assign retx_ok  = cur.initialized && (item.waited_ticks >= cur.timeout_value) && !too_soon;
	assign grown    = 12'(cur.timeout_value)
		+ 12'((11'(cur.timeout_value) + 11'd1) >> 1);

	always_comb begin
		nxt = cur;
		we  = 1'b0;
		if (cfg.enable && peer_ok) begin
			unique case (item.kind)
				KIND_SAMPLE: begin
					if (sample_ok) begin
						we                  = 1'b1;
						nxt.scaled_delivery = del_new;
						nxt.delivery_seen   = 1'b1;
						nxt.provisional     = clean ? 1'b0
							: (cur.initialized ? cur.provisional : 1'b1);
						if (add) begin
							nxt.initialized   = 1'b1;
							nxt.scaled_srtt   = srtt_new;
							nxt.scaled_rttvar = rv_new;
							nxt.timeout_value = rto_new;
						end
					end
				end
				KIND_RETX: begin
					if (retx_ok) begin
						we                    = 1'b1;
						nxt.timeout_value     = clamp_ticks(14'(grown),
							cfg.min_ticks, cfg.max_ticks);
						nxt.backed_off        = 1'b1;
						nxt.last_backoff_time = item.now_ticks;
					end
				end
				KIND_CLEAR: begin
					we  = 1'b1;
					nxt = '0;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		res          = '0;
		res.peer_out = item.peer;
		if (peer_ok) begin
			res.accepted = we;
			if (cfg.enable && nxt.initialized) begin
				res.estimate_valid = 1'b1;
				res.timeout_ticks  = clamp_ticks(14'(nxt.timeout_value),
					cfg.min_ticks, cfg.max_ticks);
			end
			if (nxt.initialized) begin
				res.smoothed_rtt   = nxt.scaled_srtt[TICK_W+2:3];
				res.rtt_variance   = nxt.scaled_rttvar[TICK_W+1:2];
				res.is_provisional = nxt.provisional;
			end
			res.delivery_valid = nxt.delivery_seen;
			if (nxt.delivery_seen) begin
				res.delivery_ticks = nxt.scaled_delivery[TICK_W+1:2];
			end
		end
	end

endmodule

// ===== rtl/rtt_timeout_estimator_core.sv =====
// ----------------------------------------------------------------------------
// rtt_timeout_estimator_core
// Per-peer retransmit timeout estimator with Karn's rule and backoff.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one report transfer for its peer. The
// block takes one item per clock cycle unless the report side stalls: the
// item is registered, then the peer's entry is read from a flip-flop table,
// updated by one pass of combinational logic and written back in the same
// cycle as the report is registered; a report follows the item and report
// registers, and back-to-back items for the same peer see each other's
// updates. The table is cleared by reset at once; no clearing pass is needed.
module rtt_timeout_estimator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// peer, delay_ticks, send_count, waited_ticks, now_ticks
	input  logic [63:0] s_tdata,
	// kind
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// peer_out, accepted, estimate_valid, timeout_ticks, smoothed_rtt,
	// rtt_variance, delivery_valid, delivery_ticks, is_provisional
	output logic [47:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_wdata
);
	import rte_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    m_valid_q;

	logic    advance;
	logic    fire;
	entry_t  cur;
	entry_t  nxt;
	logic    upd_we;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable       <= 1'b1;
			cfg_q.min_ticks    <= TICK_W'(1);
			cfg_q.max_ticks    <= TICK_W'(126);
			cfg_q.margin_ticks <= TICK_W'(4);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE: cfg_q.enable       <= cfg_wdata[0];
				CFG_MIN:    cfg_q.min_ticks    <= cfg_wdata[TICK_W-1:0];
				CFG_MAX:    cfg_q.max_ticks    <= cfg_wdata[TICK_W-1:0];
				CFG_MARGIN: cfg_q.margin_ticks <= cfg_wdata[TICK_W-1:0];
				default:    cfg_q              <= cfg_q;
			endcase
		end
	end

	assign advance  = !m_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind         <= s_tuser;
			item_s1.peer         <= s_tdata[3:0];
			item_s1.delay_ticks  <= s_tdata[13:4];
			item_s1.send_count   <= s_tdata[21:14];
			item_s1.waited_ticks <= s_tdata[31:22];
			item_s1.now_ticks    <= s_tdata[63:32];
		end
	end

	rte_peer_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (item_s1.peer[IDX_W-1:0]),
		.rdata  (cur),
		.we     (fire && upd_we),
		.waddr  (item_s1.peer[IDX_W-1:0]),
		.wdata  (nxt)
	);

	rte_update u_update (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (cur),
		.nxt  (nxt),
		.we   (upd_we),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q |-> s_tready)
		else $error("input stalled while the result register is empty");

	a_write_makes_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && upd_we) |=> (m_valid_q && res_q.accepted))
		else $error("table write without an accepted report");

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !cfg_q.enable) |-> (!res_q.accepted && !res_q.estimate_valid))
		else $error("report claims an update while disabled");

	a_timeout_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.estimate_valid && cfg_q.min_ticks <= cfg_q.max_ticks)
		|-> (res_q.timeout_ticks >= cfg_q.min_ticks
			&& res_q.timeout_ticks <= cfg_q.max_ticks))
		else $error("reported timeout outside the configured limits");

endmodule

// ===== tb/rto_report_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rto_report_checker
// Watches the item, report and register ports of the RTT timeout estimator,
// keeps its own per-peer estimator table and compares every report transfer
// field by field with the report predicted for the oldest unanswered item.
// ----------------------------------------------------------------------------
module rto_report_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_wdata,
	output int          fails,
	output int          pending
);
	import rte_pkg::*;

	logic              en;
	logic [TICK_W-1:0] lo_ticks;
	logic [TICK_W-1:0] hi_ticks;
	logic [TICK_W-1:0] floor_ticks;

	logic              est_init   [NUM_PEERS];
	logic              est_prov   [NUM_PEERS];
	logic [13:0]       srtt_x8    [NUM_PEERS];
	logic [12:0]       var_x4     [NUM_PEERS];
	logic [TICK_W-1:0] rto        [NUM_PEERS];
	logic [12:0]       dlv_x4     [NUM_PEERS];
	logic              dlv_seen   [NUM_PEERS];
	logic              backed     [NUM_PEERS];
	logic [31:0]       backoff_at [NUM_PEERS];

	result_t reports_due[$];
	int      fail_count = 0;
	int      due_count = 0;

	assign fails = fail_count;
	assign pending = due_count;

	function automatic logic [TICK_W-1:0] limit_ticks(int unsigned v);
		if (v < lo_ticks) begin
			return lo_ticks;
		end else if (v > hi_ticks) begin
			return hi_ticks;
		end
		return v[TICK_W-1:0];
	endfunction

	function automatic void clear_entry(int p);
		est_init[p] = 1'b0;
		est_prov[p] = 1'b0;
		srtt_x8[p] = '0;
		var_x4[p] = '0;
		rto[p] = '0;
		dlv_x4[p] = '0;
		dlv_seen[p] = 1'b0;
		backed[p] = 1'b0;
		backoff_at[p] = '0;
	endfunction

	// Jacobson/Karels update: the first sample seeds, later ones are blended.
	function automatic void take_rtt(int p, logic [TICK_W-1:0] d);
		int unsigned dd;
		int unsigned s;
		int unsigned mag;
		int unsigned v;
		dd = d;
		if (!est_init[p]) begin
			est_init[p] = 1'b1;
			srtt_x8[p] = 14'(dd * 8);
			var_x4[p] = (dd > 1) ? 13'(((dd + 1) / 2) * 4) : 13'd4;
		end else begin
			s = srtt_x8[p] >> 3;
			mag = (dd >= s) ? dd - s : s - dd;
			srtt_x8[p] = 14'(srtt_x8[p] - s + dd);
			v = var_x4[p] - (var_x4[p] >> 2) + mag;
			if (v < 4) begin
				v = 4;
			end
			var_x4[p] = 13'(v);
		end
		v = var_x4[p];
		if (v < floor_ticks) begin
			v = floor_ticks;
		end
		rto[p] = limit_ticks((srtt_x8[p] >> 3) + v);
	endfunction

	function automatic result_t update_estimator(logic [1:0] kind, logic [PEER_W-1:0] p,
			logic [TICK_W-1:0] d, logic [7:0] sends, logic [TICK_W-1:0] waited,
			logic [31:0] now);
		result_t     r;
		logic        acc;
		int unsigned cur;
		logic [31:0] diff;
		logic        early;
		r = '0;
		acc = 1'b0;
		r.peer_out = p;
		if (en) begin
			case (kind)
				KIND_SAMPLE: begin
					if (sends != 0 && d <= hi_ticks) begin
						acc = 1'b1;
						if (!dlv_seen[p]) begin
							dlv_x4[p] = {1'b0, d, 2'b00};
						end else begin
							dlv_x4[p] = dlv_x4[p] - (dlv_x4[p] >> 2) + 13'(d);
						end
						dlv_seen[p] = 1'b1;
						if (sends != 1) begin
							// Karn's rule: an ambiguous ack only seeds an empty entry.
							if (!est_init[p]) begin
								take_rtt(p, d);
								est_prov[p] = 1'b1;
							end
						end else begin
							if (est_prov[p]) begin
								est_init[p] = 1'b0;
								est_prov[p] = 1'b0;
							end
							take_rtt(p, d);
						end
					end
				end
				KIND_RETX: begin
					cur = rto[p];
					diff = now - backoff_at[p];
					early = backed[p] && (diff[31] || diff < cur);
					if (est_init[p] && waited >= cur && !early) begin
						rto[p] = limit_ticks(cur + (cur + 1) / 2);
						backed[p] = 1'b1;
						backoff_at[p] = now;
						acc = 1'b1;
					end
				end
				KIND_CLEAR: begin
					clear_entry(p);
					acc = 1'b1;
				end
				default: begin
				end
			endcase
		end
		r.accepted = acc;
		if (en && est_init[p]) begin
			r.estimate_valid = 1'b1;
			r.timeout_ticks = limit_ticks(rto[p]);
		end
		if (est_init[p]) begin
			r.smoothed_rtt = 10'(srtt_x8[p] >> 3);
			r.rtt_variance = 10'(var_x4[p] >> 2);
			r.is_provisional = est_prov[p];
		end
		r.delivery_valid = dlv_seen[p];
		r.delivery_ticks = dlv_seen[p] ? 10'(dlv_x4[p] >> 2) : '0;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		if (!arst_n) begin
			en = 1'b1;
			lo_ticks = 10'd1;
			hi_ticks = 10'd126;
			floor_ticks = 10'd4;
			for (int i = 0; i < NUM_PEERS; i++) begin
				clear_entry(i);
			end
			reports_due.delete();
			due_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (reports_due.size() == 0) begin
					$error("report transfer with no item outstanding: %h", m_tdata);
					fail_count++;
				end else begin
					want = reports_due.pop_front();
					check_field("peer_out", want.peer_out, got.peer_out);
					check_field("accepted", want.accepted, got.accepted);
					check_field("estimate_valid", want.estimate_valid, got.estimate_valid);
					check_field("timeout_ticks", want.timeout_ticks, got.timeout_ticks);
					check_field("smoothed_rtt", want.smoothed_rtt, got.smoothed_rtt);
					check_field("rtt_variance", want.rtt_variance, got.rtt_variance);
					check_field("delivery_valid", want.delivery_valid, got.delivery_valid);
					check_field("delivery_ticks", want.delivery_ticks, got.delivery_ticks);
					check_field("is_provisional", want.is_provisional, got.is_provisional);
				end
			end
			if (s_tvalid && s_tready) begin
				reports_due.push_back(update_estimator(s_tuser, s_tdata[3:0],
					s_tdata[13:4], s_tdata[21:14], s_tdata[31:22], s_tdata[63:32]));
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLE: en = cfg_wdata[0];
					CFG_MIN:    lo_ticks = cfg_wdata;
					CFG_MAX:    hi_ticks = cfg_wdata;
					CFG_MARGIN: floor_ticks = cfg_wdata;
					default: begin
					end
				endcase
			end
			due_count = reports_due.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample, retransmit, clear and unused-kind items into the estimator
// under bursty input and a stalling report side, walks the block through
// several register settings, and lets the report checker judge every report.
// ----------------------------------------------------------------------------
module testbench;
	import rte_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tready = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [9:0]  cfg_wdata = '0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [47:0] m_tdata;
	int          fails;
	int          pending;

	int          burst_left = 0;
	int          stall_left = 0;
	int unsigned cycle_no = 0;
	logic [31:0] clock_now;
	logic [9:0]  max_now = 10'd126;
	cfg_t        plan[8];
	int          plan_items[8];

	rtt_timeout_estimator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	rto_report_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fails(fails),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// The report side stalls in short random runs, with stall-free stretches.
	always @(negedge clk) begin
		cycle_no++;
		if (cycle_no % 512 < 96) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(logic [1:0] kind, logic [3:0] peer, logic [9:0] delay,
			logic [7:0] sends, logic [9:0] waited, logic [31:0] now);
		if (burst_left == 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {now, waited, sends, delay, peer};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [9:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_item();
		logic [1:0]  kind;
		logic [3:0]  peer;
		logic [9:0]  delay;
		logic [7:0]  sends;
		logic [9:0]  waited;
		int unsigned roll;
		int unsigned cap;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			kind = KIND_SAMPLE;
		end else if (roll < 92) begin
			kind = KIND_RETX;
		end else if (roll < 97) begin
			kind = KIND_CLEAR;
		end else begin
			kind = KIND_UNUSED;
		end
		peer = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
		cap = (max_now < 60) ? max_now : 60;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			delay = 10'($urandom_range(0, cap));
		end else if (roll < 85) begin
			delay = 10'($urandom_range(0, max_now));
		end else if (roll < 90) begin
			delay = max_now;
		end else begin
			delay = 10'($urandom);
		end
		roll = $urandom_range(0, 99);
		if (roll < 75) begin
			sends = 8'd1;
		end else if (roll < 94) begin
			sends = 8'($urandom);
		end else begin
			sends = 8'd0;
		end
		waited = $urandom_range(0, 1) ? 10'(1023 - $urandom_range(0, 200)) : 10'($urandom);
		if ($urandom_range(0, 32) == 0) begin
			clock_now = $urandom;
		end else begin
			clock_now = clock_now + $urandom_range(0, 300);
		end
		send_item(kind, peer, delay, sends, waited, clock_now);
	endtask

	initial begin
		plan[0] = '{enable: 1'b1, min_ticks: 10'd1, max_ticks: 10'd126, margin_ticks: 10'd4};
		plan[1] = '{enable: 1'b0, min_ticks: 10'd5, max_ticks: 10'd200, margin_ticks: 10'd10};
		plan[2] = '{enable: 1'b1, min_ticks: 10'd0, max_ticks: 10'd1023, margin_ticks: 10'd0};
		plan[3] = '{enable: 1'b1, min_ticks: 10'd1023, max_ticks: 10'd0,
			margin_ticks: 10'd1023};
		plan[4] = '{enable: 1'b1, min_ticks: 10'd0, max_ticks: 10'd1023,
			margin_ticks: 10'd1023};
		plan[5] = '{enable: 1'b1, min_ticks: 10'd300, max_ticks: 10'd100, margin_ticks: 10'd7};
		plan[6] = '{enable: 1'b1, min_ticks: 10'($urandom_range(0, 40)),
			max_ticks: 10'($urandom_range(50, 1023)), margin_ticks: 10'($urandom)};
		plan[7] = '{enable: 1'b1, min_ticks: 10'd2, max_ticks: 10'd60, margin_ticks: 10'd3};
		plan_items = '{150, 60, 150, 120, 150, 150, 150, 150};
		clock_now = $urandom;

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		send_item(KIND_SAMPLE, 4'd0, 10'd10, 8'd0, 10'd0, 32'd0);
		send_item(KIND_SAMPLE, 4'd0, 10'd1023, 8'd1, 10'd0, 32'd0);
		send_item(KIND_SAMPLE, 4'd0, 10'd127, 8'd1, 10'd0, 32'd10);
		send_item(KIND_RETX, 4'd0, 10'd0, 8'd0, 10'd1023, 32'd50);
		send_item(KIND_SAMPLE, 4'd0, 10'd10, 8'd3, 10'd0, 32'd60);
		send_item(KIND_SAMPLE, 4'd0, 10'd40, 8'd2, 10'd0, 32'd70);
		send_item(KIND_SAMPLE, 4'd0, 10'd126, 8'd1, 10'd0, 32'd80);
		send_item(KIND_SAMPLE, 4'd1, 10'd0, 8'd1, 10'd0, 32'd90);
		send_item(KIND_SAMPLE, 4'd1, 10'd1, 8'd1, 10'd0, 32'd95);
		send_item(KIND_RETX, 4'd1, 10'd0, 8'd0, 10'd0, 32'd100);
		send_item(KIND_RETX, 4'd1, 10'd0, 8'd0, 10'd1023, 32'd100);
		send_item(KIND_RETX, 4'd1, 10'd0, 8'd0, 10'd1023, 32'd101);
		send_item(KIND_RETX, 4'd1, 10'd0, 8'd0, 10'd1023, 32'd99);
		send_item(KIND_RETX, 4'd1, 10'd0, 8'd0, 10'd1023, 32'd1100);
		send_item(KIND_SAMPLE, 4'd2, 10'd5, 8'd255, 10'd0, 32'hFFFF_FFFF);
		send_item(KIND_RETX, 4'd2, 10'd0, 8'd0, 10'd1023, 32'hFFFF_FFFF);
		send_item(KIND_RETX, 4'd2, 10'd0, 8'd0, 10'd1023, 32'h0000_0100);
		send_item(KIND_SAMPLE, 4'd15, 10'd50, 8'd1, 10'd0, 32'h0000_0200);
		send_item(KIND_UNUSED, 4'd15, 10'd1023, 8'd255, 10'd1023, 32'hFFFF_FFFF);
		send_item(KIND_CLEAR, 4'd15, 10'd0, 8'd0, 10'd0, 32'h0000_0300);
		send_item(KIND_SAMPLE, 4'd15, 10'd30, 8'd1, 10'd0, 32'h0000_0400);
		send_item(KIND_SAMPLE, 4'd3, 10'd2, 8'd1, 10'd0, 32'h0000_0500);
		send_item(KIND_SAMPLE, 4'd3, 10'd2, 8'd1, 10'd0, 32'h0000_0600);

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			write_reg(CFG_ENABLE, {9'($urandom), plan[ph].enable});
			write_reg(CFG_MIN, plan[ph].min_ticks);
			write_reg(CFG_MAX, plan[ph].max_ticks);
			write_reg(CFG_MARGIN, plan[ph].margin_ticks);
			max_now = plan[ph].max_ticks;
			repeat (plan_items[ph]) random_item();
		end
		settle();

		if (fails == 0 && pending == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// ===== rtt_timeout_estimator_core.f =====
rtl/rte_pkg.sv
rtl/rte_peer_table.sv
rtl/rte_update.sv
rtl/rtt_timeout_estimator_core.sv
tb/rto_report_checker.sv
tb/testbench.sv
